>>> sv/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants
// Arctangent phase table, CORDIC constants and formats for the Euler
// angle to quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ATAN_TABLE_SIZE = 24;
    localparam int CORDIC_W        = 34;
    localparam int TRIG_W          = 18;
    localparam int ANGLE_W         = 17;
    localparam int QUAT_W          = 16;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [QUAT_W-1:0]   Q14_ONE = 16'sd16384;

    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        trig_t s;
        trig_t c;
    } sincos_t;

    function automatic logic [31:0] atan_phase(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion: Euler angles to unit quaternion
// Three sine/cosine lanes feed a product merge stage.
// ----------------------------------------------------------------------------
// usage:
//   input channel: valid/ready with pitch_angle, yaw_angle, roll_angle in
//   degrees scaled by 2^ANGLE_FRAC_BITS
//   output channel: valid/ready with quat_x/y/z/w in signed Q2.14
//   one item per cycle while the receiver takes results; the pipeline holds
//   the CORDIC stages of each lane, the three phase conversion stages, the
//   sine/cosine output register and the three stages of the merge
//   the whole pipeline advances together; when the receiver stalls a
//   waiting result the pipeline freezes and in_ready drops until the
//   result is taken
//   reset clears all valid bits; data registers keep whatever they hold
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  pitch_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  yaw_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  roll_angle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [e2q_pkg::QUAT_W-1:0]   quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0]   quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0]   quat_z,
    output logic signed [e2q_pkg::QUAT_W-1:0]   quat_w
);

    localparam int LAT = TRIG_ITERATIONS + 7;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           en;

    e2q_pkg::sincos_t sc_x, sc_y, sc_z;

    // advance unless a finished item waits on the receiver
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[LAT-1];
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    e2q_sincos_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                      .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane_x (
        .clk(clk), .en(en), .angle(pitch_angle), .result(sc_x));
    e2q_sincos_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                      .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane_y (
        .clk(clk), .en(en), .angle(yaw_angle), .result(sc_y));
    e2q_sincos_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                      .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane_z (
        .clk(clk), .en(en), .angle(roll_angle), .result(sc_z));

    e2q_merge u_merge (
        .clk(clk), .en(en), .lx(sc_x), .ly(sc_y), .lz(sc_z),
        .qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w));

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_w))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("ready low with empty output");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_w <= e2q_pkg::Q14_ONE && quat_w >= -e2q_pkg::Q14_ONE)
        else $error("component out of range");

endmodule

>>> sv/e2q_sincos_lane.sv
// ----------------------------------------------------------------------------
// e2q_sincos_lane: half-angle sine and cosine lane
// Phase conversion, quadrant fold and a pipelined rotation CORDIC, one
// stage per iteration. Advances when en is high.
// ----------------------------------------------------------------------------
module e2q_sincos_lane #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]    angle,
    output e2q_pkg::sincos_t                      result
);

    localparam int CW = e2q_pkg::CORDIC_W;
    localparam int NS = TRIG_ITERATIONS;
    localparam int MAG_W = e2q_pkg::ANGLE_W;
    // quotient of a 17-bit magnitude by 45
    localparam int DIV_W = 11;
    localparam int PROD_W = MAG_W + 18;
    // floor(m / 45) = (m * 186414) >> 23 for every m below 2^17
    localparam logic [17:0] RECIP_45 = 18'd186414;
    localparam int RECIP_SH = 23;
    localparam logic [MAG_W-1:0] DIV_45 = 17'd45;
    // angle * 2^(32-F) / 720 = angle * 2^(28-F) / 45
    localparam int FRAC_SH = 28 - ANGLE_FRAC_BITS;

    // stage 0: angle magnitude
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    // stage 1: whole multiples of 45
    logic [DIV_W-1:0] qest_reg;
    logic [MAG_W-1:0] mag1_reg;
    logic             neg1_reg;
    // stage 2: folded phase
    logic signed [32:0] z0_reg;
    logic               flip0_reg;

    logic signed [CW-1:0] x_reg [NS+1];
    logic signed [CW-1:0] y_reg [NS+1];
    logic signed [32:0]   z_reg [NS+1];
    logic                 flip_reg [NS+1];

    logic [MAG_W-1:0]  mag_next;
    logic [PROD_W-1:0] prod;
    logic [5:0]        rem;
    logic [31:0]       q_mag;
    logic [31:0]       ph;
    logic [31:0]       ph_fold;
    logic              fold;
    logic [31:0]       frac_tab [45];

    // rounded k * 2^(28-F) / 45, never a tie since 45 is odd
    for (genvar k = 0; k < 45; k++)
    begin : g_frac
        assign frac_tab[k] = 32'(((64'(k) << (FRAC_SH + 1)) + 64'd45) / 64'd90);
    end

    assign mag_next = angle[e2q_pkg::ANGLE_W-1] ? MAG_W'(-angle) : MAG_W'(angle);

    assign prod = PROD_W'(mag_reg) * PROD_W'(RECIP_45);

    always_comb
    begin
        rem     = 6'(mag1_reg - MAG_W'(qest_reg) * DIV_45);
        q_mag   = 32'(64'(qest_reg) << FRAC_SH) + frac_tab[rem];
        ph      = neg1_reg ? -q_mag : q_mag;
        fold    = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
        ph_fold = fold ? ph + 32'h8000_0000 : ph;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            neg_reg   <= angle[e2q_pkg::ANGLE_W-1];
            mag1_reg  <= mag_reg;
            neg1_reg  <= neg_reg;
            qest_reg  <= DIV_W'(prod >> RECIP_SH);
            z0_reg    <= 33'(signed'(ph_fold));
            flip0_reg <= fold;
        end
    end

    assign x_reg[0] = e2q_pkg::CORDIC_GAIN_Q30;
    assign y_reg[0] = '0;
    assign z_reg[0] = z0_reg;
    assign flip_reg[0] = flip0_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic signed [CW-1:0] xs_reg;
        logic signed [CW-1:0] ys_reg;
        logic signed [32:0]   zs_reg;
        logic                 fs_reg;
        logic signed [32:0]   at;
        assign at = 33'(e2q_pkg::atan_phase(i));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    xs_reg <= x_reg[i] - (y_reg[i] >>> i);
                    ys_reg <= y_reg[i] + (x_reg[i] >>> i);
                    zs_reg <= z_reg[i] - at;
                end
                else
                begin
                    xs_reg <= x_reg[i] + (y_reg[i] >>> i);
                    ys_reg <= y_reg[i] - (x_reg[i] >>> i);
                    zs_reg <= z_reg[i] + at;
                end
                fs_reg <= flip_reg[i];
            end
        end
        assign x_reg[i+1] = xs_reg;
        assign y_reg[i+1] = ys_reg;
        assign z_reg[i+1] = zs_reg;
        assign flip_reg[i+1] = fs_reg;
    end

    logic signed [CW-1:0] xo;
    logic signed [CW-1:0] yo;
    logic signed [CW-1:0] xr;
    logic signed [CW-1:0] yr;
    assign xo = flip_reg[NS] ? -x_reg[NS] : x_reg[NS];
    assign yo = flip_reg[NS] ? -y_reg[NS] : y_reg[NS];
    assign xr = (xo + CW'(1 << 13)) >>> 14;
    assign yr = (yo + CW'(1 << 13)) >>> 14;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result.c <= e2q_pkg::TRIG_W'(xr);
            result.s <= e2q_pkg::TRIG_W'(yr);
        end
    end

endmodule

>>> sv/e2q_merge.sv
// ----------------------------------------------------------------------------
// e2q_merge: quaternion product stage
// Pairwise products, then triple products, sums, rounding and clamping.
// ----------------------------------------------------------------------------
module e2q_merge (
    input  logic                                 clk,
    input  logic                                 en,
    input  e2q_pkg::sincos_t                     lx,
    input  e2q_pkg::sincos_t                     ly,
    input  e2q_pkg::sincos_t                     lz,
    output logic signed [e2q_pkg::QUAT_W-1:0]    qx,
    output logic signed [e2q_pkg::QUAT_W-1:0]    qy,
    output logic signed [e2q_pkg::QUAT_W-1:0]    qz,
    output logic signed [e2q_pkg::QUAT_W-1:0]    qw
);

    localparam int PW = 2 * e2q_pkg::TRIG_W;
    localparam int TW = PW + e2q_pkg::TRIG_W;

    logic signed [PW-1:0] cycx_reg, sysx_reg, cysx_reg, sycx_reg;
    logic signed [e2q_pkg::TRIG_W-1:0] sz_reg, cz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycx_reg <= PW'(ly.c) * PW'(lx.c);
            sysx_reg <= PW'(ly.s) * PW'(lx.s);
            cysx_reg <= PW'(ly.c) * PW'(lx.s);
            sycx_reg <= PW'(ly.s) * PW'(lx.c);
            sz_reg   <= lz.s;
            cz_reg   <= lz.c;
        end
    end

    logic signed [TW-1:0] p_reg [8];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= TW'(cysx_reg) * TW'(cz_reg);
            p_reg[1] <= TW'(sycx_reg) * TW'(sz_reg);
            p_reg[2] <= TW'(sycx_reg) * TW'(cz_reg);
            p_reg[3] <= TW'(cysx_reg) * TW'(sz_reg);
            p_reg[4] <= TW'(cycx_reg) * TW'(sz_reg);
            p_reg[5] <= TW'(sysx_reg) * TW'(cz_reg);
            p_reg[6] <= TW'(cycx_reg) * TW'(cz_reg);
            p_reg[7] <= TW'(sysx_reg) * TW'(sz_reg);
        end
    end

    function automatic logic signed [e2q_pkg::QUAT_W-1:0] to_q14(
        input logic signed [TW:0] v);
        logic signed [TW:0] r;
        r = (v + (TW+1)'(64'sd1 <<< 33)) >>> 34;
        if (r > (TW+1)'(e2q_pkg::Q14_ONE))
            r = (TW+1)'(e2q_pkg::Q14_ONE);
        if (r < -(TW+1)'(e2q_pkg::Q14_ONE))
            r = -(TW+1)'(e2q_pkg::Q14_ONE);
        return e2q_pkg::QUAT_W'(r);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx <= to_q14((TW+1)'(p_reg[0]) + (TW+1)'(p_reg[1]));
            qy <= to_q14((TW+1)'(p_reg[2]) - (TW+1)'(p_reg[3]));
            qz <= to_q14((TW+1)'(p_reg[4]) - (TW+1)'(p_reg[5]));
            qw <= to_q14((TW+1)'(p_reg[6]) + (TW+1)'(p_reg[7]));
        end
    end

endmodule

>>> sim/euler_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb: self-checking bench for the quaternion converter
// Drives angle triples with random gaps, predicts each quaternion with a
// bit-exact CORDIC model and compares results in order.
// ----------------------------------------------------------------------------
class quat_scoreboard;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    quat_t pending[$];
    int    errors;

    function new();
        errors = 0;
    endfunction

    static function longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    // sine and cosine of half the angle, Q16
    static function void half_trig(logic signed [16:0] ang, output longint s16,
                                   output longint c16);
        longint num, mag, q, z, x, y, dx, dy;
        logic [31:0] ph;
        bit flip;
        num  = longint'(ang) * (longint'(1) << (32 - 7));
        mag  = num < 0 ? -num : num;
        q    = (mag + 360) / 720;
        if (num < 0) q = -q;
        ph   = q[31:0];
        flip = 0;
        if (ph[31:30] == 2'd1 || ph[31:30] == 2'd2)
        begin
            ph   = ph + 32'h8000_0000;
            flip = 1;
        end
        z = longint'($signed(ph));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(e2q_pkg::atan_phase(i));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(e2q_pkg::atan_phase(i));
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c16 = fshift(x + (longint'(1) << 13), 14);
        s16 = fshift(y + (longint'(1) << 13), 14);
    endfunction

    static function logic signed [15:0] round_q14(longint v);
        longint r;
        r = fshift(v + (longint'(1) << 33), 34);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function void note_angles(logic signed [16:0] p, logic signed [16:0] yw,
                              logic signed [16:0] r);
        longint sx, cx, sy, cy, sz, cz;
        quat_t q;
        half_trig(p, sx, cx);
        half_trig(yw, sy, cy);
        half_trig(r, sz, cz);
        q.x = round_q14(cy * sx * cz + sy * cx * sz);
        q.y = round_q14(sy * cx * cz - cy * sx * sz);
        q.z = round_q14(cy * cx * sz - sy * sx * cz);
        q.w = round_q14(cy * cx * cz + sy * sx * sz);
        pending.push_back(q);
    endfunction

    function void check_quat(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic signed [15:0] w);
        quat_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected quaternion item");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (x !== e.x) begin $error("quat_x expected %0d got %0d", e.x, x); errors++; end
        if (y !== e.y) begin $error("quat_y expected %0d got %0d", e.y, y); errors++; end
        if (z !== e.z) begin $error("quat_z expected %0d got %0d", e.z, z); errors++; end
        if (w !== e.w) begin $error("quat_w expected %0d got %0d", e.w, w); errors++; end
    endfunction

endclass

module euler_to_quaternion_tb;

    localparam int N_RANDOM = 1850;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [16:0] pitch_angle;
    logic signed [16:0] yaw_angle;
    logic signed [16:0] roll_angle;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    quat_scoreboard sb;
    bit sending_done;
    int idle_cycles;

    euler_to_quaternion dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
        .out_valid(out_valid), .out_ready(out_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [16:0] rand_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $signed(17'($urandom_range(0, 92160)) - 17'd46080);
        if (sel < 9) return 17'($urandom);
        return sel[0] ? 17'sh0FFFF : -17'sh10000;
    endfunction

    // one angle triple, after a random gap
    task automatic send_angles(logic signed [16:0] p, logic signed [16:0] yw,
                               logic signed [16:0] r);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pitch_angle <= p;
        yaw_angle   <= yw;
        roll_angle  <= r;
        do @(posedge clk); while (!in_ready);
        sb.note_angles(p, yw, r);
    endtask

    initial
    begin
        logic signed [16:0] edges[12];
        sb = new();
        rst_n = 0;
        in_valid = 0;
        pitch_angle = 0;
        yaw_angle = 0;
        roll_angle = 0;
        sending_done = 0;
        edges = '{17'sd0, 17'sd46080, -17'sd46080, 17'sd11520, -17'sd11520,
                  17'sd23040, -17'sd23040, 17'sd34560, 17'sh0FFFF, -17'sh10000,
                  17'sd1, -17'sd1};
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, quarter turns and full-range wrap per axis
        foreach (edges[i])
        begin
            send_angles(edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12]);
        end
        send_angles(17'sd46080, 17'sd46080, 17'sd46080);
        send_angles(-17'sh10000, -17'sh10000, -17'sh10000);
        send_angles(17'sh0FFFF, 17'sh0FFFF, 17'sh0FFFF);
        send_angles(17'sd11520, 17'sd11520, 17'sd11520);
        for (int i = 0; i < N_RANDOM; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
        in_valid <= 1'b0;
        sending_done = 1;
    end

    // receiver with random backpressure, one wait drawn per item
    initial
    begin
        int stall;
        out_ready = 0;
        stall = $urandom_range(0, 4);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_quat(quat_x, quat_y, quat_z, quat_w);
                stall = $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) stall = 0;
                if (stall > 0)
                    out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                if (stall > 0)
                    stall--;
                if (stall == 0)
                    out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (sending_done && sb.pending.size() == 0)
            begin
                repeat (40) @(posedge clk);
                if (sb.errors == 0 && sb.pending.size() == 0)
                    $display("euler_to_quaternion: match");
                else
                    $display("euler_to_quaternion: mismatch");
                $finish;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("euler_to_quaternion: mismatch");
                $finish;
            end
        end
    end

endmodule
